>>> rtl/hpt_pkg.sv
// ---------------------------------------------------------------------------
// hpt_pkg: shared constants for the homogeneous point transform
// Fixed-point formats, datapath widths, register map and pipeline latency.
// ---------------------------------------------------------------------------
package hpt_pkg;

    // Number of fraction bits in every coefficient, coordinate and result.
    localparam int FRAC_BITS = 16;

    // Coordinate and coefficient width, exact product width.
    localparam int COORD_W = 32;
    localparam int PROD_W  = 2 * COORD_W;

    // Sum of three products plus growth guard.
    localparam int SUM_W = PROD_W + 2;

    // Width of a row result after the fraction shift and the offset add.
    localparam int H_W = SUM_W - FRAC_BITS + 1;

    // Width of the divider overflow comparison.
    localparam int DIV_CMP_W = H_W + COORD_W;

    // Configuration register map.
    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 64;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);

    // Register indexes of the matrix.
    typedef enum logic [CFG_IDX_W-1:0] {
        R_M00_M01, R_M02_M03, R_M10_M11, R_M12_M13,
        R_M20_M21, R_M22_M23, R_M30_M31, R_M32_M33
    } t_reg_idx;

    // One quotient bit per divider stage.
    localparam int DIV_STEPS = COORD_W;

    // Pipeline depth: two row stages, divider prep, divider steps, output.
    localparam int ROW_LAT = 2;
    localparam int DIV_LAT = DIV_STEPS + 2;
    localparam int LAT     = ROW_LAT + DIV_LAT;

    // Stream payload widths.
    localparam int TDATA_W = 3 * COORD_W;
    localparam int TUSER_W = 2;

    // Saturation limits.
    localparam logic signed [COORD_W-1:0] Q_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Fixed-point one.
    localparam logic [COORD_W-1:0] FX_ONE = COORD_W'(1) << FRAC_BITS;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [H_W-1:0]     t_row;

endpackage

>>> rtl/hpt_row.sv
// ---------------------------------------------------------------------------
// hpt_row: one matrix row times a homogeneous point
// Two stages: three signed multiplies, then the sum, fraction shift and
// the fourth-column offset.
// ---------------------------------------------------------------------------
module hpt_row
    import hpt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_coord i_p [3],
    input  t_coord i_coef [4],
    output t_row   o_h
);

    logic signed [PROD_W-1:0] r_prod [3];
    t_coord                   r_c3;
    t_row                     r_h;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  n_shift;

    // Stage one: exact products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= i_coef[k] * i_p[k];
            end
            r_c3 <= i_coef[3];
        end
    end

    // Floor of the exact sum over the fraction, then the offset.
    always_comb begin
        n_sum   = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2]);
        n_shift = n_sum >>> FRAC_BITS;
    end

    // Stage two: row result.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h <= H_W'(n_shift) + H_W'(r_c3);
        end
    end

    assign o_h = r_h;

endmodule

>>> rtl/hpt_divider.sv
// ---------------------------------------------------------------------------
// hpt_divider: pipelined fixed-point perspective divide
// Magnitude restoring division, one quotient bit per stage, with overflow
// detection up front, saturation and sign at the end. A zero divisor
// passes the saturated dividend through.
// ---------------------------------------------------------------------------
module hpt_divider
    import hpt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_row   i_h,
    input  t_row   i_w,
    output t_coord o_q,
    output logic   o_sat,
    output logic   o_wz
);

    // Per-stage payload.
    logic [H_W-1:0]     r_rem [DIV_STEPS+1];
    logic [COORD_W-1:0] r_nlo [DIV_STEPS+1];
    logic [COORD_W-1:0] r_quo [DIV_STEPS+1];
    logic [H_W-1:0]     r_den [DIV_STEPS+1];
    logic               r_neg [DIV_STEPS+1];
    logic               r_ovf [DIV_STEPS+1];
    logic               r_wz  [DIV_STEPS+1];
    logic               r_psat[DIV_STEPS+1];
    t_coord             r_pt  [DIV_STEPS+1];

    t_coord r_q;
    logic   r_sat;
    logic   r_wzo;

    logic [H_W-1:0] n_un;
    logic [H_W-1:0] n_ud;
    logic           n_hi_ok;
    logic [COORD_W-1:0] n_fq;
    logic           n_fsat;

    // Magnitudes and the passthrough range check.
    always_comb begin
        n_un    = i_h[H_W-1] ? H_W'(-i_h) : H_W'(i_h);
        n_ud    = i_w[H_W-1] ? H_W'(-i_w) : H_W'(i_w);
        n_hi_ok = (&i_h[H_W-1:COORD_W-1]) || !(|i_h[H_W-1:COORD_W-1]);
    end

    // Prep stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_un >> (COORD_W - FRAC_BITS);
            r_nlo[0]  <= {n_un[COORD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            r_quo[0]  <= '0;
            r_den[0]  <= n_ud;
            r_neg[0]  <= i_h[H_W-1] ^ i_w[H_W-1];
            // Quotient reaches 2^32 when |h| * 2^F >= |w| * 2^32.
            r_ovf[0]  <= (DIV_CMP_W'(n_un) << FRAC_BITS)
                      >= (DIV_CMP_W'(n_ud) << COORD_W);
            r_wz[0]   <= (i_w == '0);
            r_psat[0] <= !n_hi_ok;
            r_pt[0]   <= n_hi_ok ? COORD_W'(i_h) : (i_h[H_W-1] ? Q_MIN : Q_MAX);
        end
    end

    // Restoring division steps.
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        logic [H_W:0] n_t;
        logic         n_ge;

        always_comb begin
            n_t  = {r_rem[s], r_nlo[s][COORD_W-1]};
            n_ge = n_t >= {1'b0, r_den[s]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= n_ge ? H_W'(n_t - {1'b0, r_den[s]}) : H_W'(n_t);
                r_nlo[s+1]  <= r_nlo[s] << 1;
                r_quo[s+1]  <= {r_quo[s][COORD_W-2:0], n_ge};
                r_den[s+1]  <= r_den[s];
                r_neg[s+1]  <= r_neg[s];
                r_ovf[s+1]  <= r_ovf[s];
                r_wz[s+1]   <= r_wz[s];
                r_psat[s+1] <= r_psat[s];
                r_pt[s+1]   <= r_pt[s];
            end
        end
    end

    // Limit is 2^31 for a negative result, 2^31-1 otherwise.
    always_comb begin
        n_fq   = r_quo[DIV_STEPS];
        n_fsat = r_ovf[DIV_STEPS]
              || (n_fq[COORD_W-1] && (!r_neg[DIV_STEPS] || (|n_fq[COORD_W-2:0])));
    end

    // Output stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wzo <= r_wz[DIV_STEPS];
            if (r_wz[DIV_STEPS]) begin
                r_q   <= r_pt[DIV_STEPS];
                r_sat <= r_psat[DIV_STEPS];
            end else if (n_fsat) begin
                r_q   <= r_neg[DIV_STEPS] ? Q_MIN : Q_MAX;
                r_sat <= 1'b1;
            end else begin
                r_q   <= r_neg[DIV_STEPS] ? -$signed(n_fq) : $signed(n_fq);
                r_sat <= 1'b0;
            end
        end
    end

    assign o_q   = r_q;
    assign o_sat = r_sat;
    assign o_wz  = r_wzo;

endmodule

>>> rtl/homogeneous_point_transform.sv
// ---------------------------------------------------------------------------
// homogeneous_point_transform: 4x4 point transform with perspective divide
// Points in Q16.16 enter as (x, y, z, 1), leave divided by the fourth row.
// ---------------------------------------------------------------------------
// Usage:
//   The input stream carries one point per transaction in s_axis_tdata
//   (px, py, pz from the lowest bit up). The output stream carries one
//   result per transaction in m_axis_tdata (qx, qy, qz) with the flags
//   w_zero and saturated in m_axis_tuser. A triangle is three points.
//   The matrix sits in eight 64-bit registers written through i_cfg_we,
//   i_cfg_addr and i_cfg_data; write them only while no point is in flight.
//   The path from input transaction to output valid runs through two row
//   stages (multiply, sum), a divider prep stage, 32 restoring division
//   stages of one quotient bit each, and an output stage.
//   Throughput is one point per cycle, set by the fully pipelined divider;
//   a receiver stall with a result waiting holds the whole pipeline and
//   drops s_axis_tready; nothing is lost or repeated.
//   Reset clears the pipeline valid bits and loads the identity matrix.
// ---------------------------------------------------------------------------
module homogeneous_point_transform
    import hpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input points.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // px, py, pz
    // Output points.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // qx, qy, qz
    output logic [TUSER_W-1:0]   m_axis_tuser,   // w_zero, saturated
    // Matrix configuration.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [REG_W-1:0]     i_cfg_data
);

    logic [REG_W-1:0] r_cfg [NUM_REGS];
    logic             r_vld [LAT];
    logic             n_en;

    t_coord n_p    [3];
    t_coord n_coef [4][4];
    t_row   n_h    [4];
    t_coord n_q    [3];
    logic   n_sat  [3];
    logic   n_wz   [3];

    // Configuration registers, reset to the identity matrix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[R_M00_M01] <= REG_W'(FX_ONE);
            r_cfg[R_M02_M03] <= '0;
            r_cfg[R_M10_M11] <= {FX_ONE, {COORD_W{1'b0}}};
            r_cfg[R_M12_M13] <= '0;
            r_cfg[R_M20_M21] <= '0;
            r_cfg[R_M22_M23] <= REG_W'(FX_ONE);
            r_cfg[R_M30_M31] <= '0;
            r_cfg[R_M32_M33] <= {FX_ONE, {COORD_W{1'b0}}};
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_addr] <= i_cfg_data;
        end
    end

    // Coefficient unpacking: even column low half, odd column high half.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                n_coef[r][c] = (c % 2 == 1) ? r_cfg[r*2 + c/2][REG_W-1:COORD_W]
                                            : r_cfg[r*2 + c/2][COORD_W-1:0];
            end
        end
        for (int k = 0; k < 3; k++) begin
            n_p[k] = s_axis_tdata[k*COORD_W +: COORD_W];
        end
    end

    // The pipeline advances unless a result waits on a stalled receiver.
    assign n_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = n_en;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (n_en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int s = 1; s < LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Four row engines.
    for (genvar r = 0; r < 4; r++) begin : g_row
        hpt_row u_row (
            .i_clk  (i_clk),
            .i_en   (n_en),
            .i_p    (n_p),
            .i_coef (n_coef[r]),
            .o_h    (n_h[r])
        );
    end

    // Three dividers share the fourth row as divisor.
    for (genvar k = 0; k < 3; k++) begin : g_div
        hpt_divider u_div (
            .i_clk (i_clk),
            .i_en  (n_en),
            .i_h   (n_h[k]),
            .i_w   (n_h[3]),
            .o_q   (n_q[k]),
            .o_sat (n_sat[k]),
            .o_wz  (n_wz[k])
        );
    end

    // Output packing.
    assign m_axis_tvalid = r_vld[LAT-1];
    assign m_axis_tdata  = {n_q[2], n_q[1], n_q[0]};
    assign m_axis_tuser  = {n_sat[0] | n_sat[1] | n_sat[2], n_wz[0]};

    // A stalled result keeps its payload until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output result changed while stalled");

    // All three dividers see the same divisor.
    a_wz_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (n_wz[0] == n_wz[1]) && (n_wz[1] == n_wz[2]))
        else $error("divider zero-divisor flags disagree");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // An accepted point enters the first pipeline stage.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted point lost at pipeline entry");

endmodule
